@@ hdl/directed_graph_cycle_check_defines.svh @@
// assertion macros shared by the cycle check rtl
`ifndef DIRECTED_GRAPH_CYCLE_CHECK_DEFINES_SVH
`define DIRECTED_GRAPH_CYCLE_CHECK_DEFINES_SVH

// same-cycle implication, held off during reset
`define DGCC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define DGCC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/dgcc_pkg.sv @@
// shared types and constants for the directed graph cycle check
package dgcc_pkg;

   localparam int NODE_W = 8;
   localparam int CNT_W  = 9;
   localparam int ERR_W  = 2;

   // node store depth, one entry per index an 8-bit course field can name
   localparam int MAX_NODES = 256;

   localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
   localparam logic [ERR_W-1:0] ERR_RANGE    = 2'd1;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

   localparam logic ACT_EDGE = 1'b0;
   localparam logic ACT_EVAL = 1'b1;

   // mark bits per node
   localparam int MARK_ON_PATH  = 0;
   localparam int MARK_FINISHED = 1;

   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_COURSES = 2'd0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROOT,
      ST_ROOT_CHK,
      ST_SCAN,
      ST_EDGE,
      ST_MARK,
      ST_POP
   } state_type;

endpackage

@@ hdl/dgcc_ram.sv @@
// simple dual port ram with registered read
module dgcc_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/directed_graph_cycle_check.sv @@
// Edge requests are taken one per cycle while idle with no result pending; in-range ones
// are stored in the edge ram. An evaluate request runs a depth-first walk: every root is
// checked, each edge is scanned from each visited node, each edge leaving it is followed
// and the node is then retired. After the result is taken, and after reset, a clearing pass
// over all MAX_NODES mark entries wipes the mark ram; no request is taken then, csr writes
// still are. Reset is synchronous and active high; num_courses resets to 256.
module directed_graph_cycle_check #(
   parameter int MAX_EDGES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // course[7:0], prereq[15:8]
   input  logic [0:0]                        req_tuser,  // action[0]
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,  // can_finish[0], error[2:1]
   // csr port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dgcc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   import dgcc_pkg::*;

`include "directed_graph_cycle_check_defines.svh"

   localparam int NIDX_W = $clog2(MAX_NODES);
   localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECNT_W = $clog2(MAX_EDGES + 1);
   localparam int STK_W  = NODE_W + ECNT_W;
   localparam logic [NIDX_W-1:0] LAST_NODE = NIDX_W'(MAX_NODES - 1);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     num_ff, num_in;
   logic [ECNT_W-1:0]    edge_total_ff, edge_total_in;
   logic [ERR_W-1:0]     err_ff, err_in;
   logic [CNT_W-1:0]     root_ff, root_in;
   logic [NODE_W-1:0]    v_ff, v_in;
   logic [ECNT_W-1:0]    e_ff, e_in;
   logic [NIDX_W-1:0]    depth_ff, depth_in;
   logic [NIDX_W-1:0]    clr_ff, clr_in;
   logic                 can_ff, can_in;
   logic [ERR_W-1:0]     rerr_ff, rerr_in;
   logic                 done_ff, done_in;

   logic [CNT_W-1:0]     node_cnt;
   logic                 csr_wr;
   logic [NODE_W-1:0]    req_course, req_prereq;
   logic                 req_action;
   logic [NODE_W-1:0]    edge_tail, edge_head;

   logic                 mk_we, mk_re;
   logic [NIDX_W-1:0]    mk_waddr, mk_raddr;
   logic [1:0]           mk_wdata, mk_rdata;
   logic                 eg_we, eg_re;
   logic [EIDX_W-1:0]    eg_waddr, eg_raddr;
   logic [2*NODE_W-1:0]  eg_wdata, eg_rdata;
   logic                 st_we, st_re;
   logic [NIDX_W-1:0]    st_waddr, st_raddr;
   logic [STK_W-1:0]     st_wdata, st_rdata;

   // mark ram: finished and on-path bit per node
   dgcc_ram #(.DEPTH(MAX_NODES), .WIDTH(2)) u_mark_ram (
      .clock(clock), .wr_en(mk_we), .wr_addr(mk_waddr), .wr_data(mk_wdata),
      .rd_en(mk_re), .rd_addr(mk_raddr), .rd_data(mk_rdata)
   );

   // edge ram: {tail, head}
   dgcc_ram #(.DEPTH(MAX_EDGES), .WIDTH(2*NODE_W)) u_edge_ram (
      .clock(clock), .wr_en(eg_we), .wr_addr(eg_waddr), .wr_data(eg_wdata),
      .rd_en(eg_re), .rd_addr(eg_raddr), .rd_data(eg_rdata)
   );

   // walk stack ram: {node, edge cursor} of the frames below the top
   dgcc_ram #(.DEPTH(MAX_NODES), .WIDTH(STK_W)) u_stack_ram (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
      .rd_en(st_re), .rd_addr(st_raddr), .rd_data(st_rdata)
   );

   // field unpacking
   assign req_course = req_tdata[7:0];
   assign req_prereq = req_tdata[15:8];
   assign req_action = req_tuser[0];
   assign edge_tail  = eg_rdata[2*NODE_W-1:NODE_W];
   assign edge_head  = eg_rdata[NODE_W-1:0];

   // effective node count, clamped to the mark store depth
   assign node_cnt = (int'(num_ff) > MAX_NODES) ? CNT_W'(MAX_NODES) : num_ff;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == CSR_NUM_COURSES) ? {{(32-CNT_W){1'b0}}, num_ff} : 32'd0;

   // response
   assign rsp_tvalid = done_ff;
   assign rsp_tdata  = {{(8-1-ERR_W){1'b0}}, rerr_ff, can_ff};

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         num_ff        <= CNT_W'(256);
         edge_total_ff <= '0;
         err_ff        <= ERR_NONE;
         clr_ff        <= '0;
         done_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_ff        <= num_in;
         edge_total_ff <= edge_total_in;
         err_ff        <= err_in;
         clr_ff        <= clr_in;
         done_ff       <= done_in;
      end
   end

   // walk datapath registers
   always_ff @(posedge clock) begin
      root_ff  <= root_in;
      v_ff     <= v_in;
      e_ff     <= e_in;
      depth_ff <= depth_in;
      can_ff   <= can_in;
      rerr_ff  <= rerr_in;
   end

   // next state, memory accesses and load handling
   always_comb begin
      state_in      = state_ff;
      num_in        = csr_wr && (csr_paddr == CSR_NUM_COURSES) ? csr_pwdata[CNT_W-1:0] : num_ff;
      edge_total_in = edge_total_ff;
      err_in        = err_ff;
      root_in       = root_ff;
      v_in          = v_ff;
      e_in          = e_ff;
      depth_in      = depth_ff;
      clr_in        = clr_ff;
      can_in        = can_ff;
      rerr_in       = rerr_ff;
      done_in       = done_ff;
      req_tready    = 1'b0;
      mk_we = 1'b0; mk_waddr = '0; mk_wdata = '0;
      mk_re = 1'b0; mk_raddr = '0;
      eg_we = 1'b0; eg_waddr = edge_total_ff[EIDX_W-1:0]; eg_wdata = {req_prereq, req_course};
      eg_re = 1'b0; eg_raddr = e_ff[EIDX_W-1:0];
      st_we = 1'b0; st_waddr = depth_ff; st_wdata = {v_ff, e_ff};
      st_re = 1'b0; st_raddr = depth_ff - 1'b1;

      // result handshake, then clearing pass
      if (done_ff && rsp_tready) begin
         done_in       = 1'b0;
         edge_total_in = '0;
         err_in        = ERR_NONE;
         clr_in        = '0;
         state_in      = ST_CLEAR;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mk_we    = 1'b1;
            mk_waddr = clr_ff;
            if (clr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_tready = !done_ff;
            if (req_tvalid && !done_ff) begin
               if (req_action == ACT_EVAL) begin
                  root_in  = '0;
                  state_in = ST_ROOT;
               end else if ({1'b0, req_course} >= node_cnt || {1'b0, req_prereq} >= node_cnt) begin
                  if (err_ff == ERR_NONE) err_in = ERR_RANGE;
               end else if (edge_total_ff == ECNT_W'(MAX_EDGES)) begin
                  if (err_ff == ERR_NONE) err_in = ERR_OVERFLOW;
               end else begin
                  eg_we         = 1'b1;
                  edge_total_in = edge_total_ff + 1'b1;
               end
            end
         end
         ST_ROOT: begin
            if (root_ff >= node_cnt) begin
               can_in   = (err_ff == ERR_NONE);
               rerr_in  = err_ff;
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               mk_re    = 1'b1;
               mk_raddr = NIDX_W'(root_ff);
               state_in = ST_ROOT_CHK;
            end
         end
         ST_ROOT_CHK: begin
            if (mk_rdata[MARK_FINISHED]) begin
               root_in  = root_ff + 1'b1;
               state_in = ST_ROOT;
            end else begin
               mk_we    = 1'b1;
               mk_waddr = NIDX_W'(root_ff);
               mk_wdata = 2'b01 << MARK_ON_PATH;
               v_in     = root_ff[NODE_W-1:0];
               e_in     = '0;
               depth_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (e_ff >= edge_total_ff) begin
               // node exhausted: mark finished, then pop or, at the bottom, move to the next root
               mk_we    = 1'b1;
               mk_waddr = NIDX_W'(v_ff);
               mk_wdata = 2'b01 << MARK_FINISHED;
               if (depth_ff == '0) begin
                  root_in  = root_ff + 1'b1;
                  state_in = ST_ROOT;
               end else begin
                  st_re    = 1'b1;
                  depth_in = depth_ff - 1'b1;
                  state_in = ST_POP;
               end
            end else begin
               eg_re    = 1'b1;
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            e_in = e_ff + 1'b1;
            if (edge_tail == v_ff && {1'b0, edge_head} < node_cnt) begin
               mk_re    = 1'b1;
               mk_raddr = NIDX_W'(edge_head);
               state_in = ST_MARK;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_MARK: begin
            if (mk_rdata[MARK_FINISHED]) begin
               state_in = ST_SCAN;
            end else if (mk_rdata[MARK_ON_PATH]) begin
               can_in   = 1'b0;
               rerr_in  = err_ff;
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               // push current frame, descend into the edge head
               st_we    = 1'b1;
               depth_in = depth_ff + 1'b1;
               mk_we    = 1'b1;
               mk_waddr = NIDX_W'(edge_head);
               mk_wdata = 2'b01 << MARK_ON_PATH;
               v_in     = edge_head;
               e_in     = '0;
               state_in = ST_SCAN;
            end
         end
         ST_POP: begin
            v_in     = st_rdata[STK_W-1:ECNT_W];
            e_in     = st_rdata[ECNT_W-1:0];
            state_in = ST_SCAN;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   `DGCC_ASSERT_NXT(a_eval_starts, clock, reset, req_tvalid && req_tready && req_tuser[0] == ACT_EVAL, state_ff == ST_ROOT, "evaluate request did not start the walk")
   `DGCC_ASSERT_IMP(a_error_blocks_finish, clock, reset, rsp_tvalid && rsp_tdata[2:1] != ERR_NONE, rsp_tdata[0] == 1'b0, "can_finish set with an error pending")
   `DGCC_ASSERT_IMP(a_no_accept_while_busy, clock, reset, state_ff != ST_IDLE || rsp_tvalid, !req_tready, "request taken while walking or clearing")
   `DGCC_ASSERT_IMP(a_edge_total_bound, clock, reset, 1'b1, edge_total_ff <= ECNT_W'(MAX_EDGES), "edge count beyond store depth")

endmodule
